/* rtl/sseinv_pkg.sv */
`timescale 1ns / 1ps

package sseinv_pkg;

	localparam int FRAC_BITS = 16;

	// Filter weight is always unsigned Q1.16, whatever the sample format
	localparam logic [16:0] W_ONE = 17'h1_0000;

	localparam logic signed [31:0] Q_ONE  = 32'(1 << FRAC_BITS);
	localparam logic signed [31:0] Q_HALF = 32'(1 << (FRAC_BITS - 1));
	localparam logic [31:0] SPAN_MIN      = 32'((1 << FRAC_BITS) / 10000);

	// Scaled quotient is clamped here before the sign goes on
	localparam logic [33:0] QUOT_CAP = 34'h2_0000_0000;

	// Quotient bits produced by the divider; anything larger is caught up front
	localparam int DIV_STEPS = 34;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAW_MIN      = 3'd0,
		REG_RAW_MAX      = 3'd1,
		REG_REAL_MIN     = 3'd2,
		REG_REAL_MAX     = 3'd3,
		REG_VALUE_OFFSET = 3'd4,
		REG_EMA_WEIGHT   = 3'd5,
		REG_SCALE_ENABLE = 3'd6,
		REG_INVERT_MODE  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		INV_NONE    = 2'd0,
		INV_ANALOG  = 2'd1,
		INV_DIGITAL = 2'd2
	} invert_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_SCALE,
		ST_OFFSET,
		ST_FILT_A,
		ST_FILT_B,
		ST_FILT_SUM,
		ST_INVERT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_init;
		logic div_step;
		logic scale;
		logic offset;
		logic filt_a;
		logic filt_b;
		logic filt_sum;
		logic invert;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scale;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [35:0] hi;
		logic signed [35:0] lo;
		hi = 36'sh0_7FFF_FFFF;
		lo = 36'shF_8000_0000;
		if (v > hi)
			return hi[31:0];
		else if (v < lo)
			return lo[31:0];
		else
			return v[31:0];
	endfunction

endpackage

/* rtl/sseinv_ctrl.sv */
`timescale 1ns / 1ps

module sseinv_ctrl
	import sseinv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	output logic result_valid,
	input  logic result_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic result_valid_q, result_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			cnt_q          <= cnt_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		cmd            = '0;
		result_valid_d = result_valid_q;
		// drop the beat once taken
		if (result_valid_q && !result_stall)
			result_valid_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				if (sts.scale) begin
					cmd.mul = 1'b1;
					state_d = ST_DIV_INIT;
				end else begin
					state_d = ST_OFFSET;
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_OFFSET;
			end
			ST_OFFSET: begin
				cmd.offset = 1'b1;
				state_d    = ST_FILT_A;
			end
			ST_FILT_A: begin
				cmd.filt_a = 1'b1;
				state_d    = ST_FILT_B;
			end
			ST_FILT_B: begin
				cmd.filt_b = 1'b1;
				state_d    = ST_FILT_SUM;
			end
			ST_FILT_SUM: begin
				cmd.filt_sum = 1'b1;
				state_d      = ST_INVERT;
			end
			ST_INVERT: begin
				cmd.invert = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (!result_valid_q || !result_stall) begin
					cmd.emit       = 1'b1;
					result_valid_d = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

endmodule

/* rtl/sseinv_dp.sv */
`timescale 1ns / 1ps

module sseinv_dp
	import sseinv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic signed [31:0]     raw_sample,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic signed [31:0]     conditioned_value,
	output logic signed [31:0]     previous_value
);

	logic signed [31:0] raw_min_q, raw_max_q, real_min_q, real_max_q, offset_q;
	logic [16:0]        weight_q;
	logic               scale_en_q;
	logic [1:0]         invert_q;

	logic signed [31:0] val_q;
	logic [31:0]        amag_q, bmag_q, dmag_q;
	logic               neg_q, scale_q;
	logic [63:0]        prod_q;
	logic               ovf_q;
	logic [31:0]        rem_q;
	logic [33:0]        div_lo_q;
	logic [33:0]        quo_q;
	logic signed [49:0] p1_q, p2_q;
	logic signed [31:0] avg_q;
	logic               seeded_q;
	logic signed [31:0] res_q, last_q, cond_q, prev_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_min_q  <= '0;
			raw_max_q  <= Q_ONE;
			real_min_q <= '0;
			real_max_q <= Q_ONE;
			offset_q   <= '0;
			weight_q   <= W_ONE;
			scale_en_q <= 1'b0;
			invert_q   <= INV_NONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAW_MIN:      raw_min_q  <= cfg_data;
				REG_RAW_MAX:      raw_max_q  <= cfg_data;
				REG_REAL_MIN:     real_min_q <= cfg_data;
				REG_REAL_MAX:     real_max_q <= cfg_data;
				REG_VALUE_OFFSET: offset_q   <= cfg_data;
				REG_EMA_WEIGHT:   weight_q   <= cfg_data[16:0];
				REG_SCALE_ENABLE: scale_en_q <= cfg_data[0];
				REG_INVERT_MODE:  invert_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input differences and their magnitudes
	logic signed [32:0] span, a_diff, b_diff;
	logic [32:0]        span_abs, a_abs, b_abs;

	always_comb begin
		span     = {raw_max_q[31], raw_max_q} - {raw_min_q[31], raw_min_q};
		a_diff   = {raw_sample[31], raw_sample} - {raw_min_q[31], raw_min_q};
		b_diff   = {real_max_q[31], real_max_q} - {real_min_q[31], real_min_q};
		span_abs = span[32] ? 33'(-span) : 33'(span);
		a_abs    = a_diff[32] ? 33'(-a_diff) : 33'(a_diff);
		b_abs    = b_diff[32] ? 33'(-b_diff) : 33'(b_diff);
	end

	// divider step: bring down one dividend bit
	logic [32:0] trial;
	logic        fits;
	assign trial = {rem_q, div_lo_q[33]};
	assign fits  = (trial >= {1'b0, dmag_q});

	// scale result
	logic [33:0]        q_cap;
	logic signed [35:0] q_signed, scaled_sum;
	always_comb begin
		if (ovf_q || quo_q > QUOT_CAP)
			q_cap = QUOT_CAP;
		else
			q_cap = quo_q;
		q_signed   = neg_q ? -$signed({2'b00, q_cap}) : $signed({2'b00, q_cap});
		scaled_sum = q_signed + 36'(real_min_q);
	end

	// filter weight: zero or above one acts as one
	logic [16:0]        w_eff;
	logic signed [17:0] w_s, wc_s;
	assign w_eff = (weight_q == '0 || (weight_q[16] && weight_q[15:0] != '0)) ?
		W_ONE : weight_q;
	assign w_s  = $signed({1'b0, w_eff});
	assign wc_s = $signed({1'b0, W_ONE - w_eff});

	logic signed [50:0] filt_sum;
	assign filt_sum = 51'(p1_q) + 51'(p2_q) + 51'sd32768;

	logic signed [31:0] inv_val;
	always_comb begin
		case (invert_q)
			INV_ANALOG:  inv_val = sat32(36'(real_max_q) - 36'(avg_q) + 36'(real_min_q));
			INV_DIGITAL: inv_val = (avg_q > Q_HALF) ? '0 : Q_ONE;
			default:     inv_val = avg_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q   <= raw_sample;
			amag_q  <= a_abs[31:0];
			bmag_q  <= b_abs[31:0];
			dmag_q  <= span_abs[31:0];
			neg_q   <= a_diff[32] ^ b_diff[32] ^ span[32];
			scale_q <= scale_en_q && (span_abs[31:0] > SPAN_MIN);
		end
		if (cmd.mul)
			prod_q <= amag_q * bmag_q;
		if (cmd.div_init) begin
			// a quotient of 2^34 or more is clamped anyway
			ovf_q    <= ({2'b00, prod_q[63:34]} >= dmag_q);
			rem_q    <= {2'b00, prod_q[63:34]};
			div_lo_q <= prod_q[33:0];
			quo_q    <= '0;
		end
		if (cmd.div_step) begin
			rem_q    <= fits ? 32'(trial - {1'b0, dmag_q}) : trial[31:0];
			div_lo_q <= {div_lo_q[32:0], 1'b0};
			quo_q    <= {quo_q[32:0], fits};
		end
		if (cmd.scale)
			val_q <= sat32(scaled_sum);
		if (cmd.offset)
			val_q <= sat32(36'(val_q) + 36'(offset_q));
		if (cmd.filt_a)
			p1_q <= w_s * val_q;
		if (cmd.filt_b)
			p2_q <= wc_s * avg_q;
		if (cmd.invert)
			res_q <= inv_val;
		if (cmd.emit) begin
			cond_q <= res_q;
			prev_q <= last_q;
		end
	end

	// filter and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q    <= '0;
			seeded_q <= 1'b0;
			last_q   <= '0;
		end else begin
			if (cmd.filt_sum) begin
				// first sample seeds the average
				avg_q    <= seeded_q ? sat32(36'($signed(filt_sum[50:16]))) : val_q;
				seeded_q <= 1'b1;
			end
			if (cmd.emit)
				last_q <= res_q;
		end
	end

	assign sts.scale         = scale_q;
	assign conditioned_value = cond_q;
	assign previous_value    = prev_q;

endmodule

/* rtl/sensor_scale_ema_invert.sv */
`timescale 1ns / 1ps
// With range scaling, a sample passes multiply, a bit-serial divider and
// scale before offset, filter, invert and emit; without it, those are skipped.
// No new sample is taken until the current result is emitted; the next
// sample is taken while the previous result waits in the output register.
// Reset (arst_n low): configuration registers return to their defaults, filter
// unseeded, stored last result zero, no result pending.

module sensor_scale_ema_invert
	import sseinv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic signed [31:0]    raw_sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic signed [31:0]    conditioned_value,
	output logic signed [31:0]    previous_value
);

	cmd_t cmd;
	sts_t sts;

	sseinv_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	sseinv_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.raw_sample        (raw_sample),
		.cmd               (cmd),
		.sts               (sts),
		.conditioned_value (conditioned_value),
		.previous_value    (previous_value)
	);

endmodule

/* rtl/sseinv_chk.sv */
`timescale 1ns / 1ps

module sseinv_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [31:0] conditioned_value,
	input logic signed [31:0] previous_value
);

	logic               in_beat, out_beat;
	logic [1:0]         pend_q;
	logic signed [31:0] last_cv_q;

	assign in_beat  = sample_valid && !sample_stall;
	assign out_beat = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			last_cv_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
			if (out_beat)
				last_cv_q <= conditioned_value;
		end
	end

	// previous value must echo the last delivered result
	a_prev_echo: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> previous_value == last_cv_q)
		else $error("previous_value does not match last delivered result");

	// no result without a sample behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result shown with no sample outstanding");

	// at most one sample in work and one result waiting
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many samples outstanding");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(conditioned_value))
		else $error("stalled result changed");

endmodule

bind sensor_scale_ema_invert sseinv_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.sample_valid      (sample_valid),
	.sample_stall      (sample_stall),
	.result_valid      (result_valid),
	.result_stall      (result_stall),
	.conditioned_value (conditioned_value),
	.previous_value    (previous_value)
);
